FILE: rtl/wfcdt_pkg.sv
// Package for the wave-function-collapse cell domain tracker.
// Holds the widths, item kind codes and the request/response structs shared
// by the top level, the log2 unit and the divider.
package wfcdt_pkg;

    localparam int NUM_TILES   = 64;
    localparam int TILE_W      = 6;
    localparam int TCNT_W      = 7;
    localparam int WEIGHT_BITS = 16;
    localparam int SUM_W       = 22;
    localparam int LSUM_W      = 48;
    localparam int LOG_W       = 21;
    localparam int TERM_W      = WEIGHT_BITS + LOG_W;
    localparam int RND_W       = 32;
    localparam int ENT_W       = 32;
    localparam int CNT_W       = 3;

    localparam logic [CNT_W-1:0] FULL_COUNT = 3'd4;

    localparam logic [2:0] KIND_INIT   = 3'd0;
    localparam logic [2:0] KIND_LOAD   = 3'd1;
    localparam logic [2:0] KIND_REMOVE = 3'd2;
    localparam logic [2:0] KIND_ELIM   = 3'd3;
    localparam logic [2:0] KIND_COLL   = 3'd4;

    localparam logic [1:0] REG_TILES = 2'd0;
    localparam logic [1:0] REG_WSUM  = 2'd1;
    localparam logic [1:0] REG_LSUM  = 2'd2;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] x;
    } log_req_t;

    typedef struct packed {
        logic             busy;
        logic [LOG_W-1:0] result;
    } log_rsp_t;

    typedef struct packed {
        logic              start;
        logic [LSUM_W-1:0] dividend;
        logic [SUM_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic [LSUM_W-1:0] quotient;
        logic [SUM_W-1:0]  remainder;
    } div_rsp_t;

endpackage

FILE: rtl/wfc_cell_domain_tracker_core.sv
// Top level of the wave-function-collapse cell domain tracker: sequencer,
// tile memories, sums and the stream and register ports.
// Depends on wfcdt_pkg, wfcdt_log2 and wfcdt_div.
//
//  channel  | direction | beat contents
//  s_axis   | in        | tdata: kind, tile_index, tile_weight, random_value
//  m_axis   | out       | tdata: eliminated ... contradiction, one per input
//  apb      | in/out    | tiles_in_use @0, initial_weight_sum @8, init L @16
//
// An item whose weight sum is zero goes to its result beat without log2 or
// division; otherwise log2 of the sum and then the divider come first.
// An elimination also takes the weight's log2, a multiply and the subtract;
// a collapse adds two scans of tiles_in_use with the modulo between them.
// Reset restores every tile to four enablers at once; no clearing pass.
// s_axis_tready is low while an item is in work; a result waiting in the
// output register holds the sequencer only at its final step.
module wfc_cell_domain_tracker_core import wfcdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // kind, tile_index, tile_weight, random_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // eliminated, tile_possible, collapsed_valid,
                                       // collapsed_tile, entropy_q16, contradiction
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RDA   = 4'd1;
    localparam logic [3:0] ST_RDB   = 4'd2;
    localparam logic [3:0] ST_LOGW  = 4'd3;
    localparam logic [3:0] ST_MUL   = 4'd4;
    localparam logic [3:0] ST_SUB   = 4'd5;
    localparam logic [3:0] ST_SCAN1 = 4'd6;
    localparam logic [3:0] ST_MODW  = 4'd7;
    localparam logic [3:0] ST_SCAN2 = 4'd8;
    localparam logic [3:0] ST_ENT   = 4'd9;
    localparam logic [3:0] ST_LOGS  = 4'd10;
    localparam logic [3:0] ST_DIVL  = 4'd11;
    localparam logic [3:0] ST_FIN   = 4'd12;

    // Configuration registers.
    logic [TCNT_W-1:0] tiles_reg;
    logic [SUM_W-1:0]  init_ws_reg;
    logic [LSUM_W-1:0] init_ls_reg;

    // Cell state.
    logic [CNT_W-1:0]       cnt_mem [NUM_TILES];
    logic [WEIGHT_BITS-1:0] w_mem   [NUM_TILES];
    logic [NUM_TILES-1:0]   fresh_reg;
    logic [CNT_W-1:0]       cnt_q;
    logic [WEIGHT_BITS-1:0] w_q;
    logic [SUM_W-1:0]       ws_reg;
    logic [LSUM_W-1:0]      ls_reg;
    logic [TILE_W-1:0]      chosen_reg;
    logic                   cvalid_reg;

    // Item in work.
    logic [3:0]        state_reg;
    logic [2:0]        kind_reg;
    logic [TILE_W-1:0] idx_reg;
    logic [RND_W-1:0]  rnd_reg;
    logic              elim_reg;
    logic              poss_reg;
    logic              contra_reg;
    logic [WEIGHT_BITS-1:0] wsel_reg;
    logic [TERM_W-1:0] term_reg;
    logic [ENT_W-1:0]  ent_reg;
    logic [LOG_W-1:0]  logs_reg;

    // Collapse scan.
    logic [TCNT_W-1:0] sc_addr_reg;
    logic              pend_reg;
    logic [TILE_W-1:0] pend_idx_reg;
    logic [SUM_W-1:0]  total_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic              any_reg;
    logic [TILE_W-1:0] last_reg;
    logic              found_reg;
    logic [SUM_W-1:0]  r_reg;

    // Output register.
    logic        ovalid_reg;
    logic [47:0] odata_reg;

    log_req_t log_req;
    log_rsp_t log_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [TCNT_W-1:0] n_eff;
    logic              in_range;
    logic [CNT_W-1:0]  cnt_eff;
    logic              poss_now;
    logic [CNT_W-1:0]  cnt_new;
    logic              do_write;
    logic              elim_now;
    logic [TILE_W-1:0] rd_addr;
    logic              scan_issue;
    logic              scan_done;
    logic              pend_poss;
    logic [SUM_W-1:0]  acc_new;
    logic              cfg_wr;
    logic signed [49:0] ent_diff;

    wfcdt_log2 u_log2
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (log_req),
        .rsp   (log_rsp)
    );

    wfcdt_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Effective tile count and checks on the addressed tile.
    assign n_eff    = (tiles_reg > TCNT_W'(NUM_TILES)) ? TCNT_W'(NUM_TILES) : tiles_reg;
    assign in_range = ({1'b0, idx_reg} < n_eff);
    assign cnt_eff  = fresh_reg[idx_reg] ? FULL_COUNT : cnt_q;
    assign poss_now = in_range && (cnt_eff != '0);

    always_comb
    begin
        cnt_new  = cnt_eff;
        do_write = 1'b0;
        if (poss_now && (kind_reg == KIND_REMOVE))
        begin
            cnt_new  = cnt_eff - 3'd1;
            do_write = 1'b1;
        end
        else if (poss_now && (kind_reg == KIND_ELIM))
        begin
            cnt_new  = '0;
            do_write = 1'b1;
        end
    end
    assign elim_now = do_write && (cnt_new == '0);

    // Scan bookkeeping: one tile issued and one consumed per cycle.
    assign scan_issue = (sc_addr_reg < n_eff);
    assign scan_done  = !scan_issue && !pend_reg;
    assign pend_poss  = fresh_reg[pend_idx_reg] || (cnt_q != '0);
    assign acc_new    = acc_reg + SUM_W'(w_q);

    always_comb
    begin
        if ((state_reg == ST_SCAN1) || (state_reg == ST_SCAN2))
        begin
            rd_addr = sc_addr_reg[TILE_W-1:0];
        end
        else
        begin
            rd_addr = idx_reg;
        end
    end

    // Requests to the shared units.
    always_comb
    begin
        log_req.start = ((state_reg == ST_RDB) && elim_now)
                     || ((state_reg == ST_ENT) && (ws_reg != '0));
        log_req.x     = (state_reg == ST_ENT) ? ws_reg : SUM_W'(w_q);
        div_req.start = ((state_reg == ST_SCAN1) && scan_done && any_reg
                         && (total_reg != '0))
                     || ((state_reg == ST_LOGS) && !log_rsp.busy);
        if (state_reg == ST_SCAN1)
        begin
            div_req.dividend = LSUM_W'(rnd_reg);
            div_req.divisor  = total_reg;
        end
        else
        begin
            div_req.dividend = ls_reg;
            div_req.divisor  = ws_reg;
        end
    end

    // Entropy difference before saturation.
    assign ent_diff = $signed({29'b0, logs_reg}) - $signed({2'b0, div_rsp.quotient});

    // Tile memories with registered reads.
    always_ff @(posedge clk)
    begin
        cnt_q <= cnt_mem[rd_addr];
        w_q   <= w_mem[rd_addr];
        if ((state_reg == ST_RDB) && do_write)
        begin
            cnt_mem[idx_reg] <= cnt_new;
        end
        if ((state_reg == ST_IDLE) && s_axis_tvalid && (s_axis_tdata[2:0] == KIND_LOAD))
        begin
            w_mem[s_axis_tdata[8:3]] <= s_axis_tdata[24:9];
        end
    end

    // Register port.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[4:3])
            REG_TILES: prdata = 64'(tiles_reg);
            REG_WSUM:  prdata = 64'(init_ws_reg);
            REG_LSUM:  prdata = 64'(init_ls_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tiles_reg   <= TCNT_W'(64);
            init_ws_reg <= '0;
            init_ls_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:3])
                REG_TILES: tiles_reg   <= pwdata[TCNT_W-1:0];
                REG_WSUM:  init_ws_reg <= pwdata[SUM_W-1:0];
                REG_LSUM:  init_ls_reg <= pwdata[LSUM_W-1:0];
                default:   ;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fresh_reg  <= '1;
            ws_reg     <= '0;
            ls_reg     <= '0;
            chosen_reg <= '0;
            cvalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && m_axis_tready && (state_reg != ST_FIN))
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        kind_reg   <= s_axis_tdata[2:0];
                        idx_reg    <= s_axis_tdata[8:3];
                        rnd_reg    <= s_axis_tdata[56:25];
                        elim_reg   <= 1'b0;
                        contra_reg <= 1'b0;
                        if (s_axis_tdata[2:0] == KIND_INIT)
                        begin
                            fresh_reg  <= '1;
                            ws_reg     <= init_ws_reg;
                            ls_reg     <= init_ls_reg;
                            chosen_reg <= '0;
                            cvalid_reg <= 1'b0;
                        end
                        state_reg <= ST_RDA;
                    end
                end
                ST_RDA:
                begin
                    state_reg <= ST_RDB;
                end
                ST_RDB:
                begin
                    poss_reg <= in_range && (cnt_new != '0);
                    wsel_reg <= w_q;
                    if (do_write)
                    begin
                        fresh_reg[idx_reg] <= 1'b0;
                    end
                    if (elim_now)
                    begin
                        elim_reg  <= 1'b1;
                        state_reg <= ST_LOGW;
                    end
                    else if (kind_reg == KIND_COLL)
                    begin
                        sc_addr_reg <= '0;
                        pend_reg    <= 1'b0;
                        total_reg   <= '0;
                        any_reg     <= 1'b0;
                        last_reg    <= '0;
                        state_reg   <= ST_SCAN1;
                    end
                    else
                    begin
                        state_reg <= ST_ENT;
                    end
                end
                ST_LOGW:
                begin
                    if (!log_rsp.busy)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    term_reg  <= TERM_W'(wsel_reg) * TERM_W'(log_rsp.result);
                    state_reg <= ST_SUB;
                end
                ST_SUB:
                begin
                    ws_reg    <= (ws_reg > SUM_W'(wsel_reg)) ? ws_reg - SUM_W'(wsel_reg) : '0;
                    ls_reg    <= (ls_reg > LSUM_W'(term_reg)) ? ls_reg - LSUM_W'(term_reg) : '0;
                    state_reg <= ST_ENT;
                end
                ST_SCAN1:
                begin
                    if (scan_issue)
                    begin
                        sc_addr_reg <= sc_addr_reg + 7'd1;
                    end
                    pend_reg     <= scan_issue;
                    pend_idx_reg <= sc_addr_reg[TILE_W-1:0];
                    if (pend_reg && pend_poss)
                    begin
                        total_reg <= total_reg + SUM_W'(w_q);
                        any_reg   <= 1'b1;
                        last_reg  <= pend_idx_reg;
                    end
                    if (scan_done)
                    begin
                        if (!any_reg)
                        begin
                            cvalid_reg <= 1'b0;
                            chosen_reg <= '0;
                            contra_reg <= 1'b1;
                            state_reg  <= ST_ENT;
                        end
                        else
                        begin
                            cvalid_reg <= 1'b1;
                            chosen_reg <= last_reg;
                            if (total_reg == '0)
                            begin
                                state_reg <= ST_ENT;
                            end
                            else
                            begin
                                state_reg <= ST_MODW;
                            end
                        end
                    end
                end
                ST_MODW:
                begin
                    if (!div_rsp.busy)
                    begin
                        r_reg       <= div_rsp.remainder;
                        sc_addr_reg <= '0;
                        pend_reg    <= 1'b0;
                        acc_reg     <= '0;
                        found_reg   <= 1'b0;
                        state_reg   <= ST_SCAN2;
                    end
                end
                ST_SCAN2:
                begin
                    if (scan_issue)
                    begin
                        sc_addr_reg <= sc_addr_reg + 7'd1;
                    end
                    pend_reg     <= scan_issue;
                    pend_idx_reg <= sc_addr_reg[TILE_W-1:0];
                    if (pend_reg && pend_poss)
                    begin
                        acc_reg <= acc_new;
                        if (!found_reg && (r_reg < acc_new))
                        begin
                            found_reg  <= 1'b1;
                            chosen_reg <= pend_idx_reg;
                        end
                    end
                    if (scan_done)
                    begin
                        state_reg <= ST_ENT;
                    end
                end
                ST_ENT:
                begin
                    if (ws_reg == '0)
                    begin
                        ent_reg    <= '0;
                        contra_reg <= 1'b1;
                        state_reg  <= ST_FIN;
                    end
                    else
                    begin
                        state_reg <= ST_LOGS;
                    end
                end
                ST_LOGS:
                begin
                    if (!log_rsp.busy)
                    begin
                        logs_reg  <= log_rsp.result;
                        state_reg <= ST_DIVL;
                    end
                end
                ST_DIVL:
                begin
                    if (!div_rsp.busy)
                    begin
                        if (ent_diff < -50'sd2147483648)
                        begin
                            ent_reg <= 32'h8000_0000;
                        end
                        else
                        begin
                            ent_reg <= ent_diff[ENT_W-1:0];
                        end
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (!ovalid_reg || m_axis_tready)
                    begin
                        ovalid_reg <= 1'b1;
                        odata_reg  <= {6'b0, contra_reg, ent_reg,
                                       cvalid_reg ? chosen_reg : 6'd0,
                                       cvalid_reg, poss_reg, elim_reg};
                        state_reg  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/wfcdt_log2.sv
// Iterative log2 unit: normalizes a 22-bit value one bit per cycle, then
// takes sixteen fraction bits by squaring the Q1.30 mantissa. Uses wfcdt_pkg.
module wfcdt_log2 import wfcdt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  log_req_t req,
    output log_rsp_t rsp
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_NORM = 2'd1;
    localparam logic [1:0] PH_SQ   = 2'd2;

    logic [1:0]  phase_reg;
    logic [30:0] y_reg;
    logic [4:0]  n_reg;
    logic [15:0] frac_reg;
    logic [3:0]  cnt_reg;
    logic [61:0] prod;
    logic [31:0] sq;

    // One squaring of the mantissa per cycle.
    assign prod = 62'(y_reg) * 62'(y_reg);
    assign sq   = prod[61:30];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (req.start)
                    begin
                        frac_reg <= '0;
                        cnt_reg  <= '0;
                        n_reg    <= (req.x == '0) ? 5'd0 : 5'd21;
                        y_reg    <= {req.x, 9'b0};
                        if (req.x != '0)
                        begin
                            phase_reg <= PH_NORM;
                        end
                    end
                end
                PH_NORM:
                begin
                    if (y_reg[30])
                    begin
                        phase_reg <= PH_SQ;
                    end
                    else
                    begin
                        y_reg <= {y_reg[29:0], 1'b0};
                        n_reg <= n_reg - 5'd1;
                    end
                end
                PH_SQ:
                begin
                    if (sq[31])
                    begin
                        y_reg    <= sq[31:1];
                        frac_reg <= {frac_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        y_reg    <= sq[30:0];
                        frac_reg <= {frac_reg[14:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                    begin
                        phase_reg <= PH_IDLE;
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    assign rsp.busy   = (phase_reg != PH_IDLE);
    assign rsp.result = {n_reg, frac_reg};

endmodule

FILE: rtl/wfcdt_div.sv
// Restoring divider, one quotient bit per cycle for a 48-bit quotient.
// Shared by the collapse modulo and the entropy quotient. Uses wfcdt_pkg.
module wfcdt_div import wfcdt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic [5:0]        cnt_reg;
    logic [LSUM_W-1:0] quo_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  dvs_reg;
    logic [SUM_W:0]    trial;
    logic              fits;

    // Shift in the next dividend bit and try the subtraction.
    assign trial = {rem_reg, quo_reg[LSUM_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
            end
        end
        else
        begin
            if (fits)
            begin
                rem_reg <= SUM_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= trial[SUM_W-1:0];
            end
            quo_reg <= {quo_reg[LSUM_W-2:0], fits};
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'(LSUM_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: tb/sv/wfc_cell_domain_tracker_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the wave-function-collapse cell tracker core.
// Drives stream items and APB register writes, predicts every result beat.
// Depends on wfcdt_pkg and wfc_cell_domain_tracker_core.
module wfc_cell_domain_tracker_core_tb;
    import wfcdt_pkg::*;

    localparam logic [2:0] KIND_QUERY  = 3'd5;
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;
    localparam logic [4:0] ADDR_TILES  = 5'(REG_TILES) << 3;
    localparam logic [4:0] ADDR_WSUM   = 5'(REG_WSUM) << 3;
    localparam logic [4:0] ADDR_LSUM   = 5'(REG_LSUM) << 3;
    localparam logic [21:0] WSUM_MAX   = 22'd4194240;
    localparam logic [47:0] LSUM_MAX   = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic        eliminated;
        logic        tile_possible;
        logic        collapsed_valid;
        logic [5:0]  collapsed_tile;
        logic [31:0] entropy_q16;
        logic        contradiction;
    } cell_result_t;

    typedef struct {
        bit           is_cfg;
        logic [6:0]   cfg_tiles;
        logic [21:0]  cfg_wsum;
        logic [47:0]  cfg_lsum;
        logic [2:0]   kind;
        logic [5:0]   idx;
        logic [15:0]  wt;
        logic [31:0]  rnd;
        bit           typed;
        cell_result_t typed_result;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    // Predicted cell state and register copies.
    logic [6:0]  tiles_cfg;
    logic [21:0] wsum_cfg;
    logic [47:0] lsum_cfg;
    logic [2:0]  enablers [NUM_TILES];
    logic [15:0] weights [NUM_TILES];
    logic [63:0] weight_total;
    logic [63:0] log_total;
    logic [5:0]  pick_tile;
    logic        pick_valid;

    cell_result_t pending_results[$];
    stim_row_t    directed_rows[$];
    int           error_count;
    int           beats_checked;
    int           send_idle_pct;
    int           recv_idle_pct;

    wfc_cell_domain_tracker_core dut (.*);

    // Clock and a single reset pulse.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #40_000_000;
        $display("wfc_cell_domain_tracker_core verification failed");
        $finish;
    end

    // Truncated bit-serial log2 in Q16.16.
    function automatic logic [63:0] log2_q16(input logic [63:0] x);
        logic [63:0] n;
        logic [63:0] y;
        logic [63:0] frac;
        n = 0;
        frac = 0;
        if (x == 0)
            return 0;
        while (n < 40 && (x >> (n + 1)) != 0)
            n++;
        y = x << (30 - n);
        for (int i = 0; i < 16; i++)
        begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd2 << 30))
            begin
                frac = frac | 64'd1;
                y = y >> 1;
            end
        end
        return (n << 16) | frac;
    endfunction

    function automatic int active_tiles();
        return (tiles_cfg < NUM_TILES) ? int'(tiles_cfg) : NUM_TILES;
    endfunction

    // Remove a tile and take its weight terms out of the sums.
    function automatic void drop_tile(input int t);
        logic [63:0] w;
        logic [63:0] term;
        w = 64'(weights[t]);
        term = w * log2_q16(w);
        enablers[t] = '0;
        weight_total = (weight_total > w) ? weight_total - w : 64'd0;
        log_total = (log_total > term) ? log_total - term : 64'd0;
    endfunction

    function automatic logic [31:0] cell_entropy();
        longint e;
        if (weight_total == 0)
            return 32'd0;
        e = longint'(log2_q16(weight_total)) - longint'(log_total / weight_total);
        if (e < -64'sd2147483648)
            e = -64'sd2147483648;
        if (e > 64'sd2147483647)
            e = 64'sd2147483647;
        return e[31:0];
    endfunction

    // Weighted pick among the possible tiles; returns 0 when none is left.
    function automatic bit collapse_cell(input logic [31:0] rnd);
        int n;
        logic [63:0] total;
        logic [63:0] r;
        logic [63:0] acc;
        bit any;
        int last;
        n = active_tiles();
        total = 0;
        acc = 0;
        any = 0;
        last = 0;
        for (int i = 0; i < n; i++)
        begin
            if (enablers[i] > 0)
            begin
                total += weights[i];
                any = 1;
                last = i;
            end
        end
        if (!any)
        begin
            pick_valid = 1'b0;
            pick_tile = '0;
            return 0;
        end
        pick_valid = 1'b1;
        pick_tile = 6'(last);
        if (total == 0)
            return 1;
        r = 64'(rnd) % total;
        for (int i = 0; i < n; i++)
        begin
            if (enablers[i] > 0)
            begin
                acc += weights[i];
                if (r < acc)
                begin
                    pick_tile = 6'(i);
                    break;
                end
            end
        end
        return 1;
    endfunction

    // Advances the predicted cell by one item and returns its result.
    function automatic cell_result_t predict_cell(input logic [2:0] kind, input logic [5:0] idx,
                                                  input logic [15:0] wt, input logic [31:0] rnd);
        cell_result_t res;
        bit in_range;
        bit elim;
        bit contra;
        in_range = int'(idx) < active_tiles();
        elim = 0;
        contra = 0;
        case (kind)
            KIND_INIT:
            begin
                for (int i = 0; i < NUM_TILES; i++)
                    enablers[i] = FULL_COUNT;
                weight_total = 64'(wsum_cfg);
                log_total = 64'(lsum_cfg);
                pick_tile = '0;
                pick_valid = 1'b0;
            end
            KIND_LOAD:
                weights[idx] = wt;
            KIND_REMOVE:
            begin
                if (in_range && enablers[idx] > 0)
                begin
                    enablers[idx] = enablers[idx] - 3'd1;
                    if (enablers[idx] == 0)
                    begin
                        drop_tile(int'(idx));
                        elim = 1;
                    end
                end
            end
            KIND_ELIM:
            begin
                if (in_range && enablers[idx] > 0)
                begin
                    drop_tile(int'(idx));
                    elim = 1;
                end
            end
            KIND_COLL:
            begin
                if (!collapse_cell(rnd))
                    contra = 1;
            end
            default: ;
        endcase
        if (weight_total == 0)
            contra = 1;
        res.eliminated = elim;
        res.tile_possible = in_range && enablers[idx] > 0;
        res.collapsed_valid = pick_valid;
        res.collapsed_tile = pick_valid ? pick_tile : 6'd0;
        res.entropy_q16 = cell_entropy();
        res.contradiction = contra;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH beat %0d %s: got 0x%0h, expected 0x%0h",
                 beats_checked, field, got, want);
        error_count++;
    endtask

    // Send one item; the expectation is queued at the accepting edge.
    task automatic send_item(input logic [2:0] kind, input logic [5:0] idx,
                             input logic [15:0] wt, input logic [31:0] rnd,
                             input bit typed, input cell_result_t typed_result);
        int gap;
        cell_result_t predicted;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, rnd, wt, idx, kind};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = predict_cell(kind, idx, wt, rnd);
        pending_results = {pending_results, (typed ? typed_result : predicted)};
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle held until pready.
    task automatic apb_write(input logic [4:0] addr, input logic [63:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_registers(input logic [6:0] tiles, input logic [21:0] wsum,
                                 input logic [47:0] lsum);
        wait_drained();
        apb_write(ADDR_TILES, 64'(tiles));
        apb_write(ADDR_WSUM, 64'(wsum));
        apb_write(ADDR_LSUM, 64'(lsum));
        tiles_cfg = tiles;
        wsum_cfg = wsum;
        lsum_cfg = lsum;
    endtask

    function automatic void add_item(input logic [2:0] kind, input logic [5:0] idx,
                                     input logic [15:0] wt, input logic [31:0] rnd);
        stim_row_t row;
        row = '{default: '0};
        row.kind = kind;
        row.idx = idx;
        row.wt = wt;
        row.rnd = rnd;
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_typed(input logic [2:0] kind, input logic [5:0] idx,
                                      input cell_result_t want);
        stim_row_t row;
        row = '{default: '0};
        row.kind = kind;
        row.idx = idx;
        row.typed = 1;
        row.typed_result = want;
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_cfg(input logic [6:0] tiles, input logic [21:0] wsum,
                                    input logic [47:0] lsum);
        stim_row_t row;
        row = '{default: '0};
        row.is_cfg = 1;
        row.cfg_tiles = tiles;
        row.cfg_wsum = wsum;
        row.cfg_lsum = lsum;
        directed_rows = {directed_rows, row};
    endfunction

    // Output monitor and receiver stalls.
    always @(posedge clk)
    begin
        cell_result_t got;
        cell_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.eliminated = m_axis_tdata[0];
            got.tile_possible = m_axis_tdata[1];
            got.collapsed_valid = m_axis_tdata[2];
            got.collapsed_tile = m_axis_tdata[8:3];
            got.entropy_q16 = m_axis_tdata[40:9];
            got.contradiction = m_axis_tdata[41];
            if (pending_results.size() == 0)
            begin
                $display("MISMATCH result beat with no item outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.eliminated !== want.eliminated)
                    report_mismatch("eliminated", 32'(got.eliminated), 32'(want.eliminated));
                if (got.tile_possible !== want.tile_possible)
                    report_mismatch("tile_possible", 32'(got.tile_possible),
                                    32'(want.tile_possible));
                if (got.collapsed_valid !== want.collapsed_valid)
                    report_mismatch("collapsed_valid", 32'(got.collapsed_valid),
                                    32'(want.collapsed_valid));
                if (got.collapsed_tile !== want.collapsed_tile)
                    report_mismatch("collapsed_tile", 32'(got.collapsed_tile),
                                    32'(want.collapsed_tile));
                if (got.entropy_q16 !== want.entropy_q16)
                    report_mismatch("entropy_q16", got.entropy_q16, want.entropy_q16);
                if (got.contradiction !== want.contradiction)
                    report_mismatch("contradiction", 32'(got.contradiction),
                                    32'(want.contradiction));
            end
            beats_checked++;
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Main stimulus sequence.
    initial
    begin
        cell_result_t typed_res;
        logic [2:0]  kind;
        logic [5:0]  idx;
        logic [6:0]  tiles;
        logic [21:0] wsum;
        logic [47:0] lsum;
        logic [63:0] true_w;
        logic [63:0] true_l;
        int pick;
        int span;
        int phase_idle[4][2];

        phase_idle = '{'{0, 0}, '{88, 0}, '{0, 88}, '{18, 18}};
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        beats_checked = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        tiles_cfg = 7'd64;
        wsum_cfg = '0;
        lsum_cfg = '0;
        for (int i = 0; i < NUM_TILES; i++)
        begin
            enablers[i] = FULL_COUNT;
            weights[i] = '0;
        end
        weight_total = 0;
        log_total = 0;
        pick_tile = '0;
        pick_valid = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Right after reset: every tile possible, zero sum flags contradiction.
        typed_res = '{1'b0, 1'b1, 1'b0, 6'd0, 32'd0, 1'b1};
        send_item(KIND_QUERY, 6'd0, 16'd0, 32'd0, 1, typed_res);

        // Load every weight so no unwritten entry is ever read.
        for (int i = 0; i < NUM_TILES; i++)
            send_item(KIND_LOAD, 6'(i), 16'($urandom), 32'($urandom), 0, typed_res);

        // Directed table.
        add_cfg(7'd64, 22'd0, 48'd0);
        add_item(KIND_INIT, 6'd0, 16'd0, 32'd0);
        add_typed(KIND_QUERY, 6'd0, '{1'b0, 1'b1, 1'b0, 6'd0, 32'd0, 1'b1});
        add_cfg(7'd64, WSUM_MAX, LSUM_MAX);
        add_item(KIND_INIT, 6'd0, 16'd0, 32'd0);
        for (int i = 0; i < 4; i++)
            add_item(KIND_REMOVE, 6'd0, 16'hFFFF, 32'hFFFF_FFFF);
        add_item(KIND_ELIM, 6'd0, 16'd0, 32'd0);
        add_item(KIND_ELIM, 6'd63, 16'd0, 32'd0);
        add_item(KIND_COLL, 6'd0, 16'd0, 32'd0);
        add_item(KIND_COLL, 6'd63, 16'd0, 32'hFFFF_FFFF);
        add_item(KIND_LOAD, 6'd5, 16'hFFFF, 32'd0);
        add_item(KIND_SPARE6, 6'd5, 16'd0, 32'd0);
        add_item(KIND_SPARE7, 6'd63, 16'd0, 32'd0);
        add_cfg(7'd1, 22'd1, LSUM_MAX);
        add_item(KIND_INIT, 6'd0, 16'd0, 32'd0);
        add_item(KIND_REMOVE, 6'd1, 16'd0, 32'd0);
        add_item(KIND_QUERY, 6'd63, 16'd0, 32'd0);
        add_cfg(7'd0, 22'd100, 48'd0);
        add_item(KIND_INIT, 6'd0, 16'd0, 32'd0);
        add_item(KIND_COLL, 6'd0, 16'd0, 32'h1234_5678);
        add_cfg(7'd2, 22'd5, 48'd0);
        add_item(KIND_LOAD, 6'd0, 16'd0, 32'd0);
        add_item(KIND_LOAD, 6'd1, 16'd0, 32'd0);
        add_item(KIND_INIT, 6'd0, 16'd0, 32'd0);
        add_item(KIND_COLL, 6'd0, 16'd0, 32'hFFFF_FFFF);
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].is_cfg)
                set_registers(directed_rows[r].cfg_tiles, directed_rows[r].cfg_wsum,
                              directed_rows[r].cfg_lsum);
            else
                send_item(directed_rows[r].kind, directed_rows[r].idx, directed_rows[r].wt,
                          directed_rows[r].rnd, directed_rows[r].typed,
                          directed_rows[r].typed_result);
        end

        // Random phases, one per idling mode, each with several settings.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = phase_idle[ph][0];
            recv_idle_pct = phase_idle[ph][1];
            for (int seg = 0; seg < 4; seg++)
            begin
                case ($urandom_range(5))
                    0: tiles = 7'd64;
                    1: tiles = 7'd1;
                    2: tiles = 7'd127;
                    3: tiles = 7'($urandom_range(0, 7));
                    default: tiles = 7'($urandom_range(1, 64));
                endcase
                // Half the time the init sums match the loaded weights.
                true_w = 0;
                true_l = 0;
                span = (tiles < NUM_TILES) ? int'(tiles) : NUM_TILES;
                for (int i = 0; i < span; i++)
                begin
                    true_w += weights[i];
                    true_l += 64'(weights[i]) * log2_q16(64'(weights[i]));
                end
                if ($urandom_range(1))
                begin
                    wsum = true_w[21:0];
                    lsum = true_l[47:0];
                end
                else
                begin
                    wsum = ($urandom_range(3) == 0) ? WSUM_MAX
                                                    : 22'($urandom_range(0, 4194240));
                    lsum = ($urandom_range(3) == 0) ? LSUM_MAX : {16'($urandom), 32'($urandom)};
                end
                set_registers(tiles, wsum, lsum);
                send_item(KIND_INIT, 6'($urandom), 16'($urandom), 32'($urandom), 0, typed_res);
                for (int n = 0; n < 97; n++)
                begin
                    if (ph == 1 && seg == 2 && n == 40)
                    begin
                        s_axis_tvalid <= 1'b0;
                        while (pending_results.size() != 0)
                            @(posedge clk);
                    end
                    pick = $urandom_range(99);
                    if (pick < 35)
                        kind = KIND_REMOVE;
                    else if (pick < 47)
                        kind = KIND_ELIM;
                    else if (pick < 63)
                        kind = KIND_COLL;
                    else if (pick < 76)
                        kind = KIND_QUERY;
                    else if (pick < 83)
                        kind = KIND_INIT;
                    else if (pick < 95)
                        kind = KIND_LOAD;
                    else
                        kind = (pick < 97) ? KIND_SPARE6 : KIND_SPARE7;
                    if (span > 0 && $urandom_range(99) < 85)
                        idx = 6'($urandom_range(0, span - 1));
                    else
                        idx = 6'($urandom);
                    send_item(kind, idx, 16'($urandom), 32'($urandom), 0, typed_res);
                end
            end
        end

        // Drain, let the pipeline settle, then report.
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Covered %0d result beats over reset, directed and random items,", beats_checked);
        $display("four idling modes and tile counts from none up to beyond the table.");
        if (error_count == 0)
            $display("wfc_cell_domain_tracker_core verification clean");
        else
            $display("wfc_cell_domain_tracker_core verification failed");
        $finish;
    end

endmodule
